// ===== rtl/dq_pkg.sv =====
`default_nettype none

package dq_pkg;

   // Queue geometry
   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;

   // Opcodes
   localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
   localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [2:0] OP_POP_BACK   = 3'd2;
   localparam logic [2:0] OP_POP_FRONT  = 3'd3;
   localparam logic [2:0] OP_LOOK       = 3'd4;

   // Status codes
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // Per-cycle control for one row of cells
   typedef struct packed {
      logic             shift_in;   // insert at cell 0, move all one toward the tail
      logic             shift_out;  // drop cell 0, move all one toward the head
      logic             write_en;   // write one cell at write_idx
      logic [IDX_W-1:0] write_idx;
   } chain_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/dq_cell.sv =====
`default_nettype none

module dq_cell import dq_pkg::*; (
   input  wire                        clock,
   input  chain_ctl_type              ctl,
   input  wire  [IDX_W-1:0]           cell_idx,
   input  wire  signed [DATA_W-1:0]   in_value,
   input  wire  signed [DATA_W-1:0]   left_q,
   input  wire  signed [DATA_W-1:0]   right_q,
   output logic signed [DATA_W-1:0]   q,
   output logic signed [DATA_W-1:0]   d
);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;

   // Pick the next content from the neighbors, the new item or self
   always_comb begin
      if (ctl.shift_in) begin
         data_in = (cell_idx == '0) ? in_value : left_q;
      end else if (ctl.shift_out) begin
         data_in = right_q;
      end else if (ctl.write_en && (cell_idx == ctl.write_idx)) begin
         data_in = in_value;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign q = data_ff;
   assign d = data_in;

endmodule

`default_nettype wire

// ===== rtl/dq_chain.sv =====
`default_nettype none

module dq_chain import dq_pkg::*; (
   input  wire                        clock,
   input  chain_ctl_type              ctl,
   input  wire  signed [DATA_W-1:0]   in_value,
   output logic signed [DATA_W-1:0]   head_next
);

   logic signed [DATA_W-1:0] cell_q [DEPTH];
   logic signed [DATA_W-1:0] cell_d [DEPTH];

   // Build the row; each cell sees its two neighbors
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_q;
      logic signed [DATA_W-1:0] right_q;

      if (i == 0) begin : g_first
         assign left_q = in_value;
      end else begin : g_mid_l
         assign left_q = cell_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_q = '0;
      end else begin : g_mid_r
         assign right_q = cell_q[i+1];
      end

      dq_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .cell_idx (IDX_W'(i)),
         .in_value (in_value),
         .left_q   (left_q),
         .right_q  (right_q),
         .q        (cell_q[i]),
         .d        (cell_d[i])
      );
   end

   assign head_next = cell_d[0];

endmodule

`default_nettype wire

// ===== rtl/double_ended_queue_top.sv =====
`default_nettype none
// Channel   Direction  Handshake          Payload
// req       in         req_valid/stall    req_opcode, req_value
// rsp       out        rsp_valid/stall    rsp_front_value, rsp_back_value,
//                                         rsp_occupancy, rsp_status
//
// One item per cycle while no result is stalled; its result appears in the
// output register in the cycle after acceptance. Two rows of DEPTH cells hold
// the entries, one with the front at cell 0 and one with the back at cell 0,
// so both end values come from a fixed cell. Reset clears the count and the
// output valid; the cell contents are left as they are. A stalled result
// holds and blocks new items only while it is not taken.

module double_ended_queue_top import dq_pkg::*; (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire  [2:0]                 req_opcode,
   input  wire  signed [DATA_W-1:0]   req_value,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output logic signed [DATA_W-1:0]   rsp_front_value,
   output logic signed [DATA_W-1:0]   rsp_back_value,
   output logic [CNT_W-1:0]           rsp_occupancy,
   output logic [1:0]                 rsp_status
);

   logic                       accept;
   logic                       full;
   logic                       empty;
   logic [CNT_W-1:0]           count_ff;
   logic [CNT_W-1:0]           count_in;
   logic [1:0]                 status_in;
   chain_ctl_type              front_ctl;
   chain_ctl_type              back_ctl;
   logic signed [DATA_W-1:0]   front_next;
   logic signed [DATA_W-1:0]   back_next;

   logic                       rsp_valid_ff;
   logic signed [DATA_W-1:0]   front_value_ff;
   logic signed [DATA_W-1:0]   back_value_ff;
   logic [CNT_W-1:0]           occupancy_ff;
   logic [1:0]                 status_ff;

   // Take a new item unless a result is waiting and stalled
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   // Decode the operation into row controls and the new count
   always_comb begin
      front_ctl = '{shift_in: 1'b0, shift_out: 1'b0, write_en: 1'b0,
                    write_idx: count_ff[IDX_W-1:0]};
      back_ctl  = '{shift_in: 1'b0, shift_out: 1'b0, write_en: 1'b0,
                    write_idx: count_ff[IDX_W-1:0]};
      count_in  = count_ff;
      status_in = ST_DONE;
      unique case (req_opcode)
         OP_PUSH_BACK: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               back_ctl.shift_in  = accept;
               front_ctl.write_en = accept;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_PUSH_FRONT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               front_ctl.shift_in = accept;
               back_ctl.write_en  = accept;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               back_ctl.shift_out = accept;
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               front_ctl.shift_out = accept;
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_LOOK: begin
            status_in = ST_DONE;
         end
         default: begin
            status_in = ST_DONE;
         end
      endcase
   end

   dq_chain u_front_chain (
      .clock     (clock),
      .ctl       (front_ctl),
      .in_value  (req_value),
      .head_next (front_next)
   );

   dq_chain u_back_chain (
      .clock     (clock),
      .ctl       (back_ctl),
      .in_value  (req_value),
      .head_next (back_next)
   );

   // Advance the count and the result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Capture the result payload; zero the ends when the queue is empty
   always_ff @(posedge clock) begin
      if (accept) begin
         front_value_ff <= (count_in == '0) ? '0 : front_next;
         back_value_ff  <= (count_in == '0) ? '0 : back_next;
         occupancy_ff   <= count_in;
         status_ff      <= status_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_front_value = front_value_ff;
   assign rsp_back_value  = back_value_ff;
   assign rsp_occupancy   = occupancy_ff;
   assign rsp_status      = status_ff;

endmodule

`default_nettype wire
